// ----- rtl/lfsf_pkg.sv -----
// Shared types, codes and steering tables of the line follower steering unit.
`default_nettype none

package lfsf_pkg;

  // Request actions
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_REMOTE = 2'd2;

  // Command kinds
  localparam logic [1:0] CMD_DRIVE = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_PAUSE = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LO_THR    = 3'd0;
  localparam logic [2:0] REG_LI_THR    = 3'd1;
  localparam logic [2:0] REG_RI_THR    = 3'd2;
  localparam logic [2:0] REG_RO_THR    = 3'd3;
  localparam logic [2:0] REG_BLACK_THR = 3'd4;
  localparam logic [2:0] REG_LIMIT     = 3'd5;

  // Register reset values
  localparam logic [15:0] LO_THR_RST    = 16'd9000;
  localparam logic [15:0] LI_THR_RST    = 16'd8000;
  localparam logic [15:0] RI_THR_RST    = 16'd9000;
  localparam logic [15:0] RO_THR_RST    = 16'd11000;
  localparam logic [15:0] BLACK_THR_RST = 16'd20000;
  localparam logic [1:0]  LIMIT_RST     = 2'd2;

  // Drive speed of the start-up phase, hold of the pause and cap of the all-black count
  localparam logic [7:0] FIND_SPEED = 8'd100;
  localparam logic [5:0] PAUSE_MS   = 6'd50;
  localparam logic [1:0] BLACK_MAX  = 2'd3;

  // Loop bodies and recovery turns, indexed by loop number (entry 0 unused)
  localparam logic [7:0] BODY_L [10] = '{8'd0, 8'd10, 8'd255, 8'd65, 8'd255,
                                         8'd55, 8'd255, 8'd255, 8'd255, 8'd200};
  localparam logic [7:0] BODY_R [10] = '{8'd0, 8'd255, 8'd10, 8'd255, 8'd65,
                                         8'd255, 8'd55, 8'd255, 8'd200, 8'd255};
  localparam logic [5:0] BODY_H [10] = '{6'd0, 6'd1, 6'd1, 6'd1, 6'd1,
                                         6'd1, 6'd1, 6'd0, 6'd0, 6'd0};
  localparam logic [7:0] REC_L  [10] = '{8'd0, 8'd6, 8'd255, 8'd0, 8'd0,
                                         8'd0, 8'd0, 8'd0, 8'd255, 8'd120};
  localparam logic [7:0] REC_R  [10] = '{8'd0, 8'd255, 8'd6, 8'd0, 8'd0,
                                         8'd0, 8'd0, 8'd0, 8'd120, 8'd255};
  localparam logic [5:0] REC_H  [10] = '{6'd0, 6'd1, 6'd1, 6'd0, 6'd0,
                                         6'd0, 6'd0, 6'd0, 6'd0, 6'd0};

  // Program point, one-hot
  typedef enum logic [12:0] {
    PP_BUTTON = 13'b0000000000001,
    PP_FIND   = 13'b0000000000010,
    PP_REMOTE = 13'b0000000000100,
    PP_TOP    = 13'b0000000001000,
    PP_LOOP1  = 13'b0000000010000,
    PP_LOOP2  = 13'b0000000100000,
    PP_LOOP3  = 13'b0000001000000,
    PP_LOOP4  = 13'b0000010000000,
    PP_LOOP5  = 13'b0000100000000,
    PP_LOOP6  = 13'b0001000000000,
    PP_LOOP7  = 13'b0010000000000,
    PP_LOOP8  = 13'b0100000000000,
    PP_LOOP9  = 13'b1000000000000
  } pp_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] lo_thr;
    logic [15:0] li_thr;
    logic [15:0] ri_thr;
    logic [15:0] ro_thr;
    logic [15:0] black_thr;
    logic [1:0]  limit;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] lspd;
    logic [7:0] rspd;
    logic [5:0] hold;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/line_follow_steering_fsm_unit.sv -----
// Top level of the line follower steering unit: request register, result queue, registers.
//
// Requests enter on in_valid/in_ready: action (sample, start button, remote go)
// and four reflectance readings. Results leave on out_valid/out_ready, one per
// cycle while out_ready is high, each a drive, stop or pause command; last_of_run
// marks the final result of a request. A request gives zero to three results.
// A request is held in the request register and decided combinationally from
// it; its results are then written into the result queue, whose head is
// presented. Throughput: one request per cycle while each request yields at
// most one result and out_ready is high; the sustained rate is set by the
// one-result-per-cycle output queue (three entries). When the receiver stalls,
// the queue fills and the registered request waits until its results fit;
// in_ready stays low while it waits. The user must write configuration over
// the APB port (registers at byte address 4*i) only while the unit is idle;
// the block itself does not enforce this. Reset (rst, synchronous) empties the
// queue and the request register, restores the register defaults and returns
// the unit to waiting for the start button with the all-black count at zero.
`default_nettype none

module line_follow_steering_fsm_unit #(
  parameter int SENSOR_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             action,
  input  wire logic [SENSOR_BITS-1:0] left_outer,
  input  wire logic [SENSOR_BITS-1:0] left_inner,
  input  wire logic [SENSOR_BITS-1:0] right_inner,
  input  wire logic [SENSOR_BITS-1:0] right_outer,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  command_kind,
  output logic [7:0]                  left_speed,
  output logic [7:0]                  right_speed,
  output logic [5:0]                  hold_ms,
  output logic                        last_of_run,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lfsf_pkg::cfg_t cfg;
  lfsf_pkg::pp_t  pp, pp_next;
  logic [1:0]     bc, bc_next;

  logic                   s1_v;
  logic [1:0]             s1_act;
  logic [SENSOR_BITS-1:0] s1_lo, s1_li, s1_ri, s1_ro;
  logic                   s1_fire;

  lfsf_pkg::res_t res [3];
  logic [1:0]     res_n;

  lfsf_pkg::res_t q [3];
  lfsf_pkg::res_t q_next [3];
  logic [1:0]     q_cnt, q_cnt_next;
  logic           pop;
  logic [1:0]     base;
  logic [2:0]     free;
  logic [2:0]     pos;

  logic       wr_en;
  logic [2:0] reg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lo_thr    <= lfsf_pkg::LO_THR_RST;
      cfg.li_thr    <= lfsf_pkg::LI_THR_RST;
      cfg.ri_thr    <= lfsf_pkg::RI_THR_RST;
      cfg.ro_thr    <= lfsf_pkg::RO_THR_RST;
      cfg.black_thr <= lfsf_pkg::BLACK_THR_RST;
      cfg.limit     <= lfsf_pkg::LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lfsf_pkg::REG_LO_THR:    cfg.lo_thr    <= pwdata[15:0];
        lfsf_pkg::REG_LI_THR:    cfg.li_thr    <= pwdata[15:0];
        lfsf_pkg::REG_RI_THR:    cfg.ri_thr    <= pwdata[15:0];
        lfsf_pkg::REG_RO_THR:    cfg.ro_thr    <= pwdata[15:0];
        lfsf_pkg::REG_BLACK_THR: cfg.black_thr <= pwdata[15:0];
        lfsf_pkg::REG_LIMIT:     cfg.limit     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    case (reg_idx)
      lfsf_pkg::REG_LO_THR:    prdata = {16'd0, cfg.lo_thr};
      lfsf_pkg::REG_LI_THR:    prdata = {16'd0, cfg.li_thr};
      lfsf_pkg::REG_RI_THR:    prdata = {16'd0, cfg.ri_thr};
      lfsf_pkg::REG_RO_THR:    prdata = {16'd0, cfg.ro_thr};
      lfsf_pkg::REG_BLACK_THR: prdata = {16'd0, cfg.black_thr};
      lfsf_pkg::REG_LIMIT:     prdata = {30'd0, cfg.limit};
      default:                 prdata = 32'd0;
    endcase
  end

  // Request register: release when all its results fit in the queue
  assign pop     = out_valid && out_ready;
  assign free    = 3'd3 - {1'b0, q_cnt} + {2'b00, pop};
  assign s1_fire = s1_v && ({1'b0, res_n} <= free);
  assign in_ready = !s1_v || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_ready) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_act <= action;
      s1_lo  <= left_outer;
      s1_li  <= left_inner;
      s1_ri  <= right_inner;
      s1_ro  <= right_outer;
    end
  end

  // Decide the results of the held request
  lfsf_decide #(
    .SENSOR_BITS(SENSOR_BITS)
  ) u_decide (
    .action  (s1_act),
    .s_lo    (s1_lo),
    .s_li    (s1_li),
    .s_ri    (s1_ri),
    .s_ro    (s1_ro),
    .cfg     (cfg),
    .pp      (pp),
    .bc      (bc),
    .pp_next (pp_next),
    .bc_next (bc_next),
    .res     (res),
    .res_n   (res_n)
  );

  // Advance the program point and all-black count on release
  always_ff @(posedge clk) begin
    if (rst) begin
      pp <= lfsf_pkg::PP_BUTTON;
      bc <= 2'd0;
    end else if (s1_fire) begin
      pp <= pp_next;
      bc <= bc_next;
    end
  end

  // Result queue: drop the head on pop, append new results behind the rest
  assign base = q_cnt - {1'b0, pop};

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    pos       = 3'd0;
    for (int i = 0; i < 3; i++) begin
      pos = 3'(i) - {1'b0, base};
      if (s1_fire && 3'(i) >= {1'b0, base} && 3'(i) < {1'b0, base} + {1'b0, res_n}) begin
        q_next[i] = res[pos[1:0]];
      end
    end
    q_cnt_next = s1_fire ? base + res_n : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q[i] <= q_next[i];
  end

  // Present the head of the queue
  assign out_valid    = q_cnt != 2'd0;
  assign command_kind = q[0].kind;
  assign left_speed   = q[0].lspd;
  assign right_speed  = q[0].rspd;
  assign hold_ms      = q[0].hold;
  assign last_of_run  = q[0].last;

endmodule

`default_nettype wire

// ----- rtl/lfsf_decide.sv -----
// Steering decision: results and next state for one registered request.
`default_nettype none

module lfsf_decide #(
  parameter int SENSOR_BITS = 16
) (
  input  wire logic [1:0]             action,
  input  wire logic [SENSOR_BITS-1:0] s_lo,
  input  wire logic [SENSOR_BITS-1:0] s_li,
  input  wire logic [SENSOR_BITS-1:0] s_ri,
  input  wire logic [SENSOR_BITS-1:0] s_ro,
  input  wire lfsf_pkg::cfg_t         cfg,
  input  wire lfsf_pkg::pp_t          pp,
  input  wire logic [1:0]             bc,
  output lfsf_pkg::pp_t               pp_next,
  output logic [1:0]                  bc_next,
  output lfsf_pkg::res_t              res [3],
  output logic [1:0]                  res_n
);

  logic [SENSOR_BITS-1:0] t_lo, t_li, t_ri, t_ro, t_blk;
  logic lo, li, ri, ro, all_black, all_white;
  logic [9:0] cond;
  logic [3:0] k;
  logic       has_rec;
  logic [3:0] hit;
  logic       found;
  logic       stop_e, pause_e, drive_e;
  logic [7:0] d_l, d_r;
  logic [5:0] d_h;
  lfsf_pkg::res_t cand [3];
  logic [2:0] cand_e;
  logic [1:0] slot;

  // Map a loop number onto its program point
  function automatic lfsf_pkg::pp_t loop_pp(input logic [3:0] j);
    lfsf_pkg::pp_t p;
    unique case (j)
      4'd1:    p = lfsf_pkg::PP_LOOP1;
      4'd2:    p = lfsf_pkg::PP_LOOP2;
      4'd3:    p = lfsf_pkg::PP_LOOP3;
      4'd4:    p = lfsf_pkg::PP_LOOP4;
      4'd5:    p = lfsf_pkg::PP_LOOP5;
      4'd6:    p = lfsf_pkg::PP_LOOP6;
      4'd7:    p = lfsf_pkg::PP_LOOP7;
      4'd8:    p = lfsf_pkg::PP_LOOP8;
      4'd9:    p = lfsf_pkg::PP_LOOP9;
      default: p = lfsf_pkg::PP_TOP;
    endcase
    return p;
  endfunction

  // Compare readings against thresholds on the sensor width
  assign t_lo  = SENSOR_BITS'(cfg.lo_thr);
  assign t_li  = SENSOR_BITS'(cfg.li_thr);
  assign t_ri  = SENSOR_BITS'(cfg.ri_thr);
  assign t_ro  = SENSOR_BITS'(cfg.ro_thr);
  assign t_blk = SENSOR_BITS'(cfg.black_thr);

  assign lo = s_lo >= t_lo;
  assign li = s_li >= t_li;
  assign ri = s_ri >= t_ri;
  assign ro = s_ro >= t_ro;
  assign all_black = (s_lo >= t_blk) && (s_li >= t_blk) && (s_ri >= t_blk) && (s_ro >= t_blk);
  assign all_white = !lo && !li && !ri && !ro;

  // Loop entry tests
  assign cond[0] = 1'b0;
  assign cond[1] = lo;
  assign cond[2] = ro;
  assign cond[3] = lo && li;
  assign cond[4] = ro && ri;
  assign cond[5] = lo && li && ri;
  assign cond[6] = ro && ri && li;
  assign cond[7] = ri && li && !ro && !lo;
  assign cond[8] = ri;
  assign cond[9] = li;

  // Loop number of the current point; the top restarts the search at loop one
  always_comb begin
    unique case (pp)
      lfsf_pkg::PP_LOOP1: k = 4'd1;
      lfsf_pkg::PP_LOOP2: k = 4'd2;
      lfsf_pkg::PP_LOOP3: k = 4'd3;
      lfsf_pkg::PP_LOOP4: k = 4'd4;
      lfsf_pkg::PP_LOOP5: k = 4'd5;
      lfsf_pkg::PP_LOOP6: k = 4'd6;
      lfsf_pkg::PP_LOOP7: k = 4'd7;
      lfsf_pkg::PP_LOOP8: k = 4'd8;
      lfsf_pkg::PP_LOOP9: k = 4'd9;
      default:            k = 4'd1;
    endcase
  end

  assign has_rec = (k == 4'd1) || (k == 4'd2) || (k == 4'd8) || (k == 4'd9);

  // Find the first loop at or after k whose test passes
  always_comb begin
    hit   = 4'd0;
    found = 1'b0;
    for (int j = 9; j >= 1; j--) begin
      if (4'(j) >= k && cond[j]) begin
        hit   = 4'(j);
        found = 1'b1;
      end
    end
  end

  // Main decision
  always_comb begin
    pp_next = pp;
    bc_next = bc;
    stop_e  = 1'b0;
    pause_e = 1'b0;
    drive_e = 1'b0;
    d_l     = 8'd0;
    d_r     = 8'd0;
    d_h     = 6'd0;
    unique case (pp)
      lfsf_pkg::PP_BUTTON: begin
        if (action == lfsf_pkg::ACT_BUTTON) pp_next = lfsf_pkg::PP_FIND;
      end
      lfsf_pkg::PP_REMOTE: begin
        if (action == lfsf_pkg::ACT_REMOTE) pp_next = lfsf_pkg::PP_TOP;
      end
      lfsf_pkg::PP_FIND: begin
        if (action == lfsf_pkg::ACT_SAMPLE) begin
          drive_e = 1'b1;
          d_h     = 6'd1;
          if (all_black) begin
            pp_next = lfsf_pkg::PP_REMOTE;
          end else begin
            d_l = lfsf_pkg::FIND_SPEED;
            d_r = lfsf_pkg::FIND_SPEED;
          end
        end
      end
      default: begin
        // top of the chain and the nine loops
        if (action == lfsf_pkg::ACT_SAMPLE) begin
          if (pp != lfsf_pkg::PP_TOP && has_rec && all_white) begin
            drive_e = 1'b1;
            d_l     = lfsf_pkg::REC_L[k];
            d_r     = lfsf_pkg::REC_R[k];
            d_h     = lfsf_pkg::REC_H[k];
          end else begin
            if (pp != lfsf_pkg::PP_TOP && all_black) begin
              if (bc != lfsf_pkg::BLACK_MAX) bc_next = bc + 2'd1;
              stop_e  = bc_next > cfg.limit;
              pause_e = 1'b1;
            end
            pp_next = loop_pp(hit);
            if (found) begin
              drive_e = 1'b1;
              d_l     = lfsf_pkg::BODY_L[hit];
              d_r     = lfsf_pkg::BODY_R[hit];
              d_h     = lfsf_pkg::BODY_H[hit];
            end
          end
        end
      end
    endcase
  end

  // Candidate results in emission order: stop, pause, drive
  always_comb begin
    cand[0] = '{kind: lfsf_pkg::CMD_STOP, lspd: 8'd0, rspd: 8'd0, hold: 6'd0, last: 1'b0};
    cand[1] = '{kind: lfsf_pkg::CMD_PAUSE, lspd: 8'd0, rspd: 8'd0,
                hold: lfsf_pkg::PAUSE_MS, last: 1'b0};
    cand[2] = '{kind: lfsf_pkg::CMD_DRIVE, lspd: d_l, rspd: d_r, hold: d_h, last: 1'b0};
  end

  assign cand_e = {drive_e, pause_e, stop_e};

  // Pack enabled candidates to the front and mark the final one
  always_comb begin
    slot = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = cand[2];
    for (int i = 0; i < 3; i++) begin
      if (cand_e[i]) begin
        res[slot] = cand[i];
        slot      = slot + 2'd1;
      end
    end
    res_n = slot;
    for (int i = 0; i < 3; i++) res[i].last = (2'(i) == res_n - 2'd1);
  end

endmodule

`default_nettype wire
